@@ rtl/wes_pkg.sv @@
// Package for the wheel encoder speed estimator: constants, register indexes,
// datapath op codes, controller states and the saturation helper.
// No dependencies.
package wes_pkg;

  localparam int CounterBits = 32;
  localparam logic [31:0] CntMask = 32'((64'd1 << CounterBits) - 64'd1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgLeftPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRightPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleMs    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLeftCpr     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRightCpr    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDiameter    = 3'd5;

  localparam logic [31:0] RstLeftPeriod  = 32'hFFFF_FFFF;
  localparam logic [31:0] RstRightPeriod = 32'd65535;
  localparam logic [15:0] RstSampleMs    = 16'd200;
  localparam logic [15:0] RstCpr         = 16'd390;
  localparam logic [9:0]  RstDiameter    = 10'd65;

  localparam logic [19:0] CntScale = 20'd10000;
  localparam logic [19:0] RevScale = 20'd1000000;
  localparam logic [19:0] PiX10000 = 20'd31416;

  // divider iterations: counter reduction and rate quotients
  localparam logic [5:0] ModIters  = 6'd32;
  localparam logic [5:0] RateIters = 6'd57;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_MODC, OP_ST_C, OP_DIV_MODP, OP_ST_P, OP_DELTA, OP_DEN,
    OP_MUL_CNT, OP_DIV_CNT, OP_ST_CNT, OP_MUL_REV, OP_DIV_REV, OP_ST_REV,
    OP_MUL_PI, OP_MUL_DIA, OP_DIV_SPD, OP_ST_SPD, OP_COMMIT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MODC, ST_MODC_W, ST_MODP, ST_MODP_W, ST_DELTA, ST_DEN,
    ST_MUL_CNT, ST_DIV_CNT, ST_WAIT_CNT, ST_MUL_REV, ST_DIV_REV, ST_WAIT_REV,
    ST_MUL_PI, ST_MUL_DIA, ST_DIV_SPD, ST_WAIT_SPD, ST_NEXT, ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic wheel;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } stat_t;

  function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'h8000_0000;
      else                     r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                     r = mag[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/wes_if.sv @@
// Request channels of the wheel encoder speed estimator.
// Depends on nothing; used by the top level and the datapath.
interface wes_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_raw_count;
  logic [31:0] right_raw_count;

  modport source (output valid, left_raw_count, right_raw_count, input ready);
  modport sink   (input valid, left_raw_count, right_raw_count, output ready);
endinterface

interface wes_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] left_count_step;
  logic signed [31:0] right_count_step;
  logic signed [31:0] left_counts_rate_x10;
  logic signed [31:0] right_counts_rate_x10;
  logic signed [31:0] left_revs_rate_x1000;
  logic signed [31:0] right_revs_rate_x1000;
  logic signed [31:0] left_speed_mm_x10;
  logic signed [31:0] right_speed_mm_x10;

  modport source (output valid, left_count_step, right_count_step, left_counts_rate_x10,
                  right_counts_rate_x10, left_revs_rate_x1000, right_revs_rate_x1000,
                  left_speed_mm_x10, right_speed_mm_x10, input ready);
  modport sink   (input valid, left_count_step, right_count_step, left_counts_rate_x10,
                  right_counts_rate_x10, left_revs_rate_x1000, right_revs_rate_x1000,
                  left_speed_mm_x10, right_speed_mm_x10, output ready);
endinterface

@@ rtl/wes_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Dividend arrives top-aligned; iteration count selects the width used.
// Depends on nothing.
module wes_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  input  logic [5:0]  iters_i,
  output logic        busy_o,
  output logic [63:0] quo_o,
  output logic [32:0] rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] dvs_q, dvs_d;
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;

  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[32:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/wes_dp.sv @@
// Datapath: configuration registers, previous snapshots, shared multiplier,
// divider instance, result slots and output register.
// Depends on wes_pkg, wes_if and wes_div.
module wes_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wes_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wes_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic [31:0]                     left_raw_i,
  input  logic [31:0]                     right_raw_i,
  input  wes_pkg::cmd_t                   cmd_i,
  output wes_pkg::stat_t                  stat_o,
  wes_out_if.source                       out_ch
);

  logic [31:0] per_q [2];
  logic [15:0] cpr_q [2];
  logic [15:0] sms_q;
  logic [9:0]  dia_q;

  logic [31:0] cur_q  [2];
  logic [31:0] prev_q [2];
  logic [31:0] c_q, p_q;
  logic [30:0] mag_q;
  logic        neg_q;
  logic [31:0] den_q;
  logic [63:0] prod_q;
  logic [31:0] dlt_q [2];
  logic [31:0] cnt_q [2];
  logic [31:0] rev_q [2];
  logic [31:0] spd_q [2];

  logic        out_valid_q;
  logic [31:0] o_dlt_q [2];
  logic [31:0] o_cnt_q [2];
  logic [31:0] o_rev_q [2];
  logic [31:0] o_spd_q [2];

  logic        w;
  logic [32:0] range_w;
  logic [32:0] fwd, bwd;
  logic        d_neg;
  logic [30:0] d_mag;

  logic [47:0] mul_a;
  logic [19:0] mul_b;
  logic [67:0] mul_p;

  logic        div_start;
  logic [63:0] div_dvd;
  logic [32:0] div_dvs;
  logic [5:0]  div_it;
  logic        div_busy;
  logic [63:0] div_quo;
  logic [32:0] div_rem;

  assign w       = cmd_i.wheel;
  assign range_w = {1'b0, per_q[w]} + 33'd1;

  always_comb begin
    if (c_q >= p_q) fwd = {1'b0, c_q} - {1'b0, p_q};
    else            fwd = range_w - {1'b0, p_q} + {1'b0, c_q};
    if (p_q >= c_q) bwd = {1'b0, p_q} - {1'b0, c_q};
    else            bwd = range_w - {1'b0, c_q} + {1'b0, p_q};
    if (fwd <= bwd) begin
      d_neg = 1'b0;
      d_mag = (fwd > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : fwd[30:0];
    end else begin
      d_neg = (bwd != 33'd0);
      d_mag = bwd[30:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      wes_pkg::OP_DEN:     begin mul_a = {32'd0, sms_q};    mul_b = {4'd0, cpr_q[w]}; end
      wes_pkg::OP_MUL_CNT: begin mul_a = {17'd0, mag_q};    mul_b = wes_pkg::CntScale; end
      wes_pkg::OP_MUL_REV: begin mul_a = {17'd0, mag_q};    mul_b = wes_pkg::RevScale; end
      wes_pkg::OP_MUL_PI:  begin mul_a = {17'd0, mag_q};    mul_b = wes_pkg::PiX10000; end
      wes_pkg::OP_MUL_DIA: begin mul_a = prod_q[47:0];      mul_b = {10'd0, dia_q}; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {prod_q[56:0], 7'd0};
    div_dvs   = {1'b0, den_q};
    div_it    = wes_pkg::RateIters;
    unique case (cmd_i.op)
      wes_pkg::OP_DIV_MODC: begin
        div_start = 1'b1;
        div_dvd   = {cur_q[w], 32'd0};
        div_dvs   = range_w;
        div_it    = wes_pkg::ModIters;
      end
      wes_pkg::OP_DIV_MODP: begin
        div_start = 1'b1;
        div_dvd   = {prev_q[w], 32'd0};
        div_dvs   = range_w;
        div_it    = wes_pkg::ModIters;
      end
      wes_pkg::OP_DIV_CNT: begin
        div_start = 1'b1;
        div_dvs   = {17'd0, sms_q};
      end
      wes_pkg::OP_DIV_REV, wes_pkg::OP_DIV_SPD: div_start = 1'b1;
      default: ;
    endcase
  end

  wes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .iters_i    (div_it),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q[0]    <= wes_pkg::RstLeftPeriod;
      per_q[1]    <= wes_pkg::RstRightPeriod;
      sms_q       <= wes_pkg::RstSampleMs;
      cpr_q[0]    <= wes_pkg::RstCpr;
      cpr_q[1]    <= wes_pkg::RstCpr;
      dia_q       <= wes_pkg::RstDiameter;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wes_pkg::CfgLeftPeriod:  per_q[0] <= cfg_wdata_i;
          wes_pkg::CfgRightPeriod: per_q[1] <= cfg_wdata_i;
          wes_pkg::CfgSampleMs:    sms_q    <= cfg_wdata_i[15:0];
          wes_pkg::CfgLeftCpr:     cpr_q[0] <= cfg_wdata_i[15:0];
          wes_pkg::CfgRightCpr:    cpr_q[1] <= cfg_wdata_i[15:0];
          wes_pkg::CfgDiameter:    dia_q    <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.op == wes_pkg::OP_COMMIT) begin
        out_valid_q <= 1'b1;
        prev_q[0]   <= cur_q[0];
        prev_q[1]   <= cur_q[1];
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      wes_pkg::OP_LOAD: begin
        cur_q[0] <= left_raw_i & wes_pkg::CntMask;
        cur_q[1] <= right_raw_i & wes_pkg::CntMask;
      end
      wes_pkg::OP_ST_C:  c_q <= div_rem[31:0];
      wes_pkg::OP_ST_P:  p_q <= div_rem[31:0];
      wes_pkg::OP_DELTA: begin
        mag_q    <= d_mag;
        neg_q    <= d_neg;
        dlt_q[w] <= wes_pkg::sat_s32(d_neg, {33'd0, d_mag});
      end
      wes_pkg::OP_DEN: den_q <= mul_p[31:0];
      wes_pkg::OP_MUL_CNT, wes_pkg::OP_MUL_REV, wes_pkg::OP_MUL_PI,
      wes_pkg::OP_MUL_DIA: prod_q <= mul_p[63:0];
      wes_pkg::OP_ST_CNT:
        cnt_q[w] <= (sms_q == 16'd0) ? 32'd0 : wes_pkg::sat_s32(neg_q, div_quo);
      wes_pkg::OP_ST_REV:
        rev_q[w] <= (den_q == 32'd0) ? 32'd0 : wes_pkg::sat_s32(neg_q, div_quo);
      wes_pkg::OP_ST_SPD:
        spd_q[w] <= (den_q == 32'd0) ? 32'd0 : wes_pkg::sat_s32(neg_q, div_quo);
      wes_pkg::OP_COMMIT: begin
        o_dlt_q <= dlt_q;
        o_cnt_q <= cnt_q;
        o_rev_q <= rev_q;
        o_spd_q <= spd_q;
      end
      default: ;
    endcase
  end

  assign stat_o.div_busy = div_busy;
  assign stat_o.out_busy = out_valid_q && !out_ch.ready;

  assign out_ch.valid                 = out_valid_q;
  assign out_ch.left_count_step       = o_dlt_q[0];
  assign out_ch.right_count_step      = o_dlt_q[1];
  assign out_ch.left_counts_rate_x10  = o_cnt_q[0];
  assign out_ch.right_counts_rate_x10 = o_cnt_q[1];
  assign out_ch.left_revs_rate_x1000  = o_rev_q[0];
  assign out_ch.right_revs_rate_x1000 = o_rev_q[1];
  assign out_ch.left_speed_mm_x10     = o_spd_q[0];
  assign out_ch.right_speed_mm_x10    = o_spd_q[1];

endmodule

@@ rtl/wes_ctrl.sv @@
// Controller: sequences reduction, delta, products and divisions per wheel.
// Depends on wes_pkg.
module wes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wes_pkg::stat_t stat_i,
  output wes_pkg::cmd_t  cmd_o
);

  wes_pkg::state_e state_q, state_d;
  logic            wheel_q, wheel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wes_pkg::ST_IDLE;
      wheel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wheel_q <= wheel_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    wheel_d      = wheel_q;
    cmd_o.op     = wes_pkg::OP_NONE;
    cmd_o.wheel  = wheel_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      wes_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wes_pkg::OP_LOAD;
          wheel_d  = 1'b0;
          state_d  = wes_pkg::ST_MODC;
        end
      end
      wes_pkg::ST_MODC: begin
        cmd_o.op = wes_pkg::OP_DIV_MODC;
        state_d  = wes_pkg::ST_MODC_W;
      end
      wes_pkg::ST_MODC_W: if (!stat_i.div_busy) begin
        cmd_o.op = wes_pkg::OP_ST_C;
        state_d  = wes_pkg::ST_MODP;
      end
      wes_pkg::ST_MODP: begin
        cmd_o.op = wes_pkg::OP_DIV_MODP;
        state_d  = wes_pkg::ST_MODP_W;
      end
      wes_pkg::ST_MODP_W: if (!stat_i.div_busy) begin
        cmd_o.op = wes_pkg::OP_ST_P;
        state_d  = wes_pkg::ST_DELTA;
      end
      wes_pkg::ST_DELTA: begin
        cmd_o.op = wes_pkg::OP_DELTA;
        state_d  = wes_pkg::ST_DEN;
      end
      wes_pkg::ST_DEN: begin
        cmd_o.op = wes_pkg::OP_DEN;
        state_d  = wes_pkg::ST_MUL_CNT;
      end
      wes_pkg::ST_MUL_CNT: begin
        cmd_o.op = wes_pkg::OP_MUL_CNT;
        state_d  = wes_pkg::ST_DIV_CNT;
      end
      wes_pkg::ST_DIV_CNT: begin
        cmd_o.op = wes_pkg::OP_DIV_CNT;
        state_d  = wes_pkg::ST_WAIT_CNT;
      end
      wes_pkg::ST_WAIT_CNT: if (!stat_i.div_busy) begin
        cmd_o.op = wes_pkg::OP_ST_CNT;
        state_d  = wes_pkg::ST_MUL_REV;
      end
      wes_pkg::ST_MUL_REV: begin
        cmd_o.op = wes_pkg::OP_MUL_REV;
        state_d  = wes_pkg::ST_DIV_REV;
      end
      wes_pkg::ST_DIV_REV: begin
        cmd_o.op = wes_pkg::OP_DIV_REV;
        state_d  = wes_pkg::ST_WAIT_REV;
      end
      wes_pkg::ST_WAIT_REV: if (!stat_i.div_busy) begin
        cmd_o.op = wes_pkg::OP_ST_REV;
        state_d  = wes_pkg::ST_MUL_PI;
      end
      wes_pkg::ST_MUL_PI: begin
        cmd_o.op = wes_pkg::OP_MUL_PI;
        state_d  = wes_pkg::ST_MUL_DIA;
      end
      wes_pkg::ST_MUL_DIA: begin
        cmd_o.op = wes_pkg::OP_MUL_DIA;
        state_d  = wes_pkg::ST_DIV_SPD;
      end
      wes_pkg::ST_DIV_SPD: begin
        cmd_o.op = wes_pkg::OP_DIV_SPD;
        state_d  = wes_pkg::ST_WAIT_SPD;
      end
      wes_pkg::ST_WAIT_SPD: if (!stat_i.div_busy) begin
        cmd_o.op = wes_pkg::OP_ST_SPD;
        state_d  = wes_pkg::ST_NEXT;
      end
      wes_pkg::ST_NEXT: begin
        if (!wheel_q) begin
          wheel_d = 1'b1;
          state_d = wes_pkg::ST_MODC;
        end else begin
          state_d = wes_pkg::ST_OUT;
        end
      end
      wes_pkg::ST_OUT: if (!stat_i.out_busy) begin
        cmd_o.op = wes_pkg::OP_COMMIT;
        state_d  = wes_pkg::ST_IDLE;
      end
      default: state_d = wes_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/wheel_encoder_speed_estimator.sv @@
// Two-wheel encoder speed estimator, top level.
// Input channel in_ch carries one left and one right counter snapshot per
// request; output channel out_ch returns one request of eight signed results
// (deltas, count rates x10, revolution rates x1000, speeds mm/s x10).
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
// write only while the block is idle.
// A new request is taken once the previous one has been moved into the output
// register. The work runs in sequence on the single shared one-bit-per-cycle
// divider: per wheel two 32-step counter reductions and three 57-step rate
// divisions.
// Reset restores the default configuration, clears the kept snapshots to
// zero and empties the output register.
// A stalled receiver holds the output register; the following request is
// still computed and waits in the controller until the output register frees.
// Depends on wes_pkg, wes_if, wes_dp and wes_ctrl.
module wheel_encoder_speed_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wes_pkg::CfgDataW-1:0] cfg_wdata_i,
  wes_in_if.sink                       in_ch,
  wes_out_if.source                    out_ch
);

  wes_pkg::cmd_t  cmd;
  wes_pkg::stat_t stat;

  wes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wes_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .left_raw_i  (in_ch.left_raw_count),
    .right_raw_i (in_ch.right_raw_count),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ch      (out_ch)
  );

`ifndef SYNTH
  a_accept_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |-> !stat.div_busy)
    else $error("request accepted while divider busy");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second request taken during computation");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == wes_pkg::OP_COMMIT |-> !stat.out_busy)
    else $error("result committed over a pending output");
`endif

endmodule
